>>> rtl/ptpsync_pkg.sv
package ptpsync_pkg;

  // ns / 1e9 == (ns >> 9) / 5^9; the low 9 bits pass straight into the remainder
  localparam int LOW_BITS   = 9;
  localparam int DIV_STEPS  = 35;                      // quotient bits (seconds < 2^35)
  localparam int REM_W      = 21;                      // 5^9 < 2^21
  localparam int STEP_BITS  = 5;                       // quotient bits per stage
  localparam int DIV_STAGES = DIV_STEPS / STEP_BITS;
  localparam int LATENCY    = DIV_STAGES + 2;          // entry + divider + checksum
  localparam int SUM_W      = 20;                      // room for six 16-bit terms

  localparam logic [REM_W-1:0] DIVISOR       = 21'd1953125;
  localparam logic [29:0]      NS_PER_SEC    = 30'd1000000000;
  localparam logic [15:0]      CSUM_ALL_ONES = 16'hffff;

  // partial remainder plus a shift register: dividend bits leave at the top,
  // quotient bits enter at the bottom
  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] dq;
  } div_t;

  typedef struct packed {
    logic                is_udp;
    logic                csum_offload;
    logic [15:0]         old_udp_sum;
    logic [15:0]         old_part;     // folded sum of the inverted old words
    logic [LOW_BITS-1:0] ns_low;
    logic [8:0]          corr_offset;
  } side_t;

  // end-around carry fold; result is zero only for a zero input
  function automatic logic [15:0] fold16(input logic [SUM_W-1:0] x);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, x[15:0]} + 17'(x[SUM_W-1:16]);
    s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
    return s2[15:0];
  endfunction

endpackage

>>> rtl/ptp_sync_origin_timestamp_rewrite_top.sv
// One-step PTP Sync originTimestamp rewrite.
// Input: a transaction is taken on each clock edge with start high and busy
// low. It carries the 64-bit nanosecond time, the frame's UDP/offload flags,
// the old UDP checksum, the old originTimestamp words and the correction
// field offset.
// Output: out_valid is high for exactly one cycle per transaction, with the
// new seconds (high/low), nanoseconds, UDP checksum, checksum-fix flag and
// the correction offset. Results leave in order of arrival.
// Pipeline: entry register, seven divider stages of five quotient bits each,
// checksum register. Throughput: one transaction per cycle; the pipeline
// never holds.
// The depth is set by the 35-bit restoring division by 5^9.
// Reset: synchronous, active low; clears all valid bits, in-flight
// transactions are dropped, and busy stays high until the first clock edge
// that samples rst_n high. Afterwards busy is low for good.
// The receiver cannot stall: out_valid is never held and results must be
// taken in the cycle they appear.
module ptp_sync_origin_timestamp_rewrite_top
  import ptpsync_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_time_ns,
  input  logic        in_is_udp,
  input  logic        in_csum_offload,
  input  logic [15:0] in_old_udp_sum,
  input  logic [15:0] in_old_sec_high,
  input  logic [31:0] in_old_sec_low,
  input  logic [31:0] in_old_nanosec,
  input  logic [8:0]  in_corr_offset,
  output logic        out_valid,
  output logic [15:0] out_sec_high,
  output logic [31:0] out_sec_low,
  output logic [29:0] out_nanosec,
  output logic [15:0] out_new_udp_sum,
  output logic        out_csum_fix,
  output logic [8:0]  out_step_offset
);

  logic             busy_r;
  logic             valid0_r;
  div_t             div0_r;
  div_t             div0_nxt;
  side_t            side0_r;
  side_t            side0_nxt;
  logic [SUM_W-1:0] old_sum_v;

  logic  valid_pipe [0:DIV_STAGES];
  div_t  div_pipe   [0:DIV_STAGES];
  side_t side_pipe  [0:DIV_STAGES];

  // inverted old words, summed now so the last stage only adds the new ones
  assign old_sum_v = {{(SUM_W-16){1'b0}}, ~in_old_udp_sum}
                   + {{(SUM_W-16){1'b0}}, ~in_old_sec_high}
                   + {{(SUM_W-16){1'b0}}, ~in_old_sec_low[31:16]}
                   + {{(SUM_W-16){1'b0}}, ~in_old_sec_low[15:0]}
                   + {{(SUM_W-16){1'b0}}, ~in_old_nanosec[31:16]}
                   + {{(SUM_W-16){1'b0}}, ~in_old_nanosec[15:0]};

  always_comb begin
    // top dividend bits are below the divisor, so they seed the remainder
    div0_nxt.rem           = REM_W'(in_time_ns[63:LOW_BITS+DIV_STEPS]);
    div0_nxt.dq            = in_time_ns[LOW_BITS+DIV_STEPS-1:LOW_BITS];
    side0_nxt.is_udp       = in_is_udp;
    side0_nxt.csum_offload = in_csum_offload;
    side0_nxt.old_udp_sum  = in_old_udp_sum;
    side0_nxt.old_part     = fold16(old_sum_v);
    side0_nxt.ns_low       = in_time_ns[LOW_BITS-1:0];
    side0_nxt.corr_offset  = in_corr_offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      valid0_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      valid0_r <= start && !busy_r;
    end
    div0_r  <= div0_nxt;
    side0_r <= side0_nxt;
  end

  assign busy = busy_r;

  assign valid_pipe[0] = valid0_r;
  assign div_pipe[0]   = div0_r;
  assign side_pipe[0]  = side0_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ptpsync_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_pipe[g]),
      .in_div    (div_pipe[g]),
      .in_side   (side_pipe[g]),
      .out_valid (valid_pipe[g+1]),
      .out_div   (div_pipe[g+1]),
      .out_side  (side_pipe[g+1])
    );
  end

  ptpsync_csum u_csum (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (valid_pipe[DIV_STAGES]),
    .in_div          (div_pipe[DIV_STAGES]),
    .in_side         (side_pipe[DIV_STAGES]),
    .out_valid       (out_valid),
    .out_sec_high    (out_sec_high),
    .out_sec_low     (out_sec_low),
    .out_nanosec     (out_nanosec),
    .out_new_udp_sum (out_new_udp_sum),
    .out_csum_fix    (out_csum_fix),
    .out_step_offset (out_step_offset)
  );

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transaction did not come out after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted transaction");

  a_ns_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nanosec < NS_PER_SEC))
    else $error("nanoseconds remainder out of range");

  a_sec_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sec_high[15:3] == 13'd0))
    else $error("seconds value exceeds quotient width");

endmodule

>>> rtl/ptpsync_div_stage.sv
module ptpsync_div_stage
  import ptpsync_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  div_t  in_div,
  input  side_t in_side,
  output logic  out_valid,
  output div_t  out_div,
  output side_t out_side
);

  logic             valid_r;
  div_t             div_r;
  div_t             div_nxt;
  side_t            side_r;
  logic [REM_W-1:0] rem_v;
  logic [DIV_STEPS-1:0] dq_v;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // restoring division, STEP_BITS quotient bits per stage
  always_comb begin
    rem_v = in_div.rem;
    dq_v  = in_div.dq;
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int j = 0; j < STEP_BITS; j++) begin
      trial = {rem_v, dq_v[DIV_STEPS-1]};
      diff  = trial - {1'b0, DIVISOR};
      ge    = (trial >= {1'b0, DIVISOR});
      dq_v  = {dq_v[DIV_STEPS-2:0], ge};
      rem_v = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
    div_nxt.rem = rem_v;
    div_nxt.dq  = dq_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    div_r  <= div_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

>>> rtl/ptpsync_csum.sv
module ptpsync_csum
  import ptpsync_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  div_t        in_div,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [15:0] out_sec_high,
  output logic [31:0] out_sec_low,
  output logic [29:0] out_nanosec,
  output logic [15:0] out_new_udp_sum,
  output logic        out_csum_fix,
  output logic [8:0]  out_step_offset
);

  logic             valid_r;
  logic [15:0]      sec_high_r;
  logic [31:0]      sec_low_r;
  logic [29:0]      nanosec_r;
  logic [15:0]      udp_sum_r;
  logic [15:0]      udp_sum_nxt;
  logic             fix_r;
  logic             fix_nxt;
  logic [8:0]       offset_r;
  logic [15:0]      sec_high_v;
  logic [29:0]      ns_v;
  logic [SUM_W-1:0] sum_v;
  logic [15:0]      upd_v;

  assign sec_high_v = 16'(in_div.dq >> 32);
  assign ns_v       = {in_div.rem, in_side.ns_low};

  // old words already folded in upstream; add the new words here
  assign sum_v = SUM_W'(in_side.old_part) + SUM_W'(sec_high_v)
               + SUM_W'(in_div.dq[31:16]) + SUM_W'(in_div.dq[15:0])
               + SUM_W'(ns_v[29:16]) + SUM_W'(ns_v[15:0]);
  assign upd_v = ~fold16(sum_v);

  always_comb begin
    udp_sum_nxt = in_side.old_udp_sum;
    fix_nxt     = 1'b0;
    if (in_side.is_udp) begin
      if (in_side.csum_offload) begin
        fix_nxt = 1'b1;
      end else if (in_side.old_udp_sum != 16'd0) begin
        // zero on the wire means no checksum
        udp_sum_nxt = (upd_v == 16'd0) ? CSUM_ALL_ONES : upd_v;
        fix_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    sec_high_r <= sec_high_v;
    sec_low_r  <= in_div.dq[31:0];
    nanosec_r  <= ns_v;
    udp_sum_r  <= udp_sum_nxt;
    fix_r      <= fix_nxt;
    offset_r   <= in_side.corr_offset;
  end

  assign out_valid       = valid_r;
  assign out_sec_high    = sec_high_r;
  assign out_sec_low     = sec_low_r;
  assign out_nanosec     = nanosec_r;
  assign out_new_udp_sum = udp_sum_r;
  assign out_csum_fix    = fix_r;
  assign out_step_offset = offset_r;

endmodule

>>> test/origin_ts_checker.sv
module origin_ts_checker
  import ptpsync_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_time_ns,
  input  logic        in_is_udp,
  input  logic        in_csum_offload,
  input  logic [15:0] in_old_udp_sum,
  input  logic [15:0] in_old_sec_high,
  input  logic [31:0] in_old_sec_low,
  input  logic [31:0] in_old_nanosec,
  input  logic [8:0]  in_corr_offset,
  input  logic        out_valid,
  input  logic [15:0] out_sec_high,
  input  logic [31:0] out_sec_low,
  input  logic [29:0] out_nanosec,
  input  logic [15:0] out_new_udp_sum,
  input  logic        out_csum_fix,
  input  logic [8:0]  out_step_offset,
  output int          pending,
  output int          mismatch_count
);

  typedef struct packed {
    logic [15:0] sec_high;
    logic [31:0] sec_low;
    logic [29:0] nanosec;
    logic [15:0] udp_sum;
    logic        csum_fix;
    logic [8:0]  step_offset;
  } origin_stamp_t;

  origin_stamp_t expected_stamps[$];

  initial begin
    pending        = 0;
    mismatch_count = 0;
  end

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

  function automatic origin_stamp_t rewrite_origin_ts(
    input logic [63:0] t,
    input logic        udp,
    input logic        offl,
    input logic [15:0] old_sum,
    input logic [15:0] old_sh,
    input logic [31:0] old_sl,
    input logic [31:0] old_ns,
    input logic [8:0]  corr
  );
    origin_stamp_t r;
    logic [63:0]   secs;
    logic [63:0]   rem;
    logic [15:0]   acc;
    secs          = t / 64'(NS_PER_SEC);
    rem           = t % 64'(NS_PER_SEC);
    r.sec_high    = secs[47:32];
    r.sec_low     = secs[31:0];
    r.nanosec     = rem[29:0];
    r.udp_sum     = old_sum;
    r.csum_fix    = 1'b0;
    r.step_offset = corr;
    if (udp) begin
      if (offl) begin
        r.csum_fix = 1'b1;
      end else if (old_sum != 16'd0) begin
        // HC' = ~(~HC + ~m + m') over the five replaced words
        acc = ~old_sum;
        acc = oc_add(acc, ~old_sh);
        acc = oc_add(acc, ~old_sl[31:16]);
        acc = oc_add(acc, ~old_sl[15:0]);
        acc = oc_add(acc, ~old_ns[31:16]);
        acc = oc_add(acc, ~old_ns[15:0]);
        acc = oc_add(acc, secs[47:32]);
        acc = oc_add(acc, secs[31:16]);
        acc = oc_add(acc, secs[15:0]);
        acc = oc_add(acc, {2'b00, rem[29:16]});
        acc = oc_add(acc, rem[15:0]);
        acc = ~acc;
        // zero on the wire means no checksum
        r.udp_sum  = (acc == 16'd0) ? CSUM_ALL_ONES : acc;
        r.csum_fix = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    origin_stamp_t want;
    if (!rst_n) begin
      expected_stamps.delete();
      pending = 0;
    end else begin
      if (out_valid) begin
        if (expected_stamps.size() == 0) begin
          report_mismatch("result with no transaction pending", 64'(out_sec_low), 64'd0);
        end else begin
          want = expected_stamps.pop_front();
          if (out_sec_high !== want.sec_high)
            report_mismatch("sec_high", 64'(out_sec_high), 64'(want.sec_high));
          if (out_sec_low !== want.sec_low)
            report_mismatch("sec_low", 64'(out_sec_low), 64'(want.sec_low));
          if (out_nanosec !== want.nanosec)
            report_mismatch("nanosec", 64'(out_nanosec), 64'(want.nanosec));
          if (out_new_udp_sum !== want.udp_sum)
            report_mismatch("new_udp_sum", 64'(out_new_udp_sum), 64'(want.udp_sum));
          if (out_csum_fix !== want.csum_fix)
            report_mismatch("csum_fix", 64'(out_csum_fix), 64'(want.csum_fix));
          if (out_step_offset !== want.step_offset)
            report_mismatch("step_offset", 64'(out_step_offset), 64'(want.step_offset));
        end
      end
      if (start && !busy) begin
        expected_stamps.push_back(rewrite_origin_ts(in_time_ns, in_is_udp, in_csum_offload,
                                                    in_old_udp_sum, in_old_sec_high,
                                                    in_old_sec_low, in_old_nanosec,
                                                    in_corr_offset));
      end
      pending = expected_stamps.size();
    end
  end

endmodule

>>> test/ptp_sync_origin_timestamp_rewrite_top_test.sv
module ptp_sync_origin_timestamp_rewrite_top_test;
  import ptpsync_pkg::*;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] NS_SEC64 = 64'd1000000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_time_ns;
  logic        in_is_udp;
  logic        in_csum_offload;
  logic [15:0] in_old_udp_sum;
  logic [15:0] in_old_sec_high;
  logic [31:0] in_old_sec_low;
  logic [31:0] in_old_nanosec;
  logic [8:0]  in_corr_offset;
  logic        out_valid;
  logic [15:0] out_sec_high;
  logic [31:0] out_sec_low;
  logic [29:0] out_nanosec;
  logic [15:0] out_new_udp_sum;
  logic        out_csum_fix;
  logic [8:0]  out_step_offset;
  int          pending;
  int          mismatch_count;
  int          idle_cycles;

  ptp_sync_origin_timestamp_rewrite_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_time_ns      (in_time_ns),
    .in_is_udp       (in_is_udp),
    .in_csum_offload (in_csum_offload),
    .in_old_udp_sum  (in_old_udp_sum),
    .in_old_sec_high (in_old_sec_high),
    .in_old_sec_low  (in_old_sec_low),
    .in_old_nanosec  (in_old_nanosec),
    .in_corr_offset  (in_corr_offset),
    .out_valid       (out_valid),
    .out_sec_high    (out_sec_high),
    .out_sec_low     (out_sec_low),
    .out_nanosec     (out_nanosec),
    .out_new_udp_sum (out_new_udp_sum),
    .out_csum_fix    (out_csum_fix),
    .out_step_offset (out_step_offset)
  );

  origin_ts_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_time_ns      (in_time_ns),
    .in_is_udp       (in_is_udp),
    .in_csum_offload (in_csum_offload),
    .in_old_udp_sum  (in_old_udp_sum),
    .in_old_sec_high (in_old_sec_high),
    .in_old_sec_low  (in_old_sec_low),
    .in_old_nanosec  (in_old_nanosec),
    .in_corr_offset  (in_corr_offset),
    .out_valid       (out_valid),
    .out_sec_high    (out_sec_high),
    .out_sec_low     (out_sec_low),
    .out_nanosec     (out_nanosec),
    .out_new_udp_sum (out_new_udp_sum),
    .out_csum_fix    (out_csum_fix),
    .out_step_offset (out_step_offset),
    .pending         (pending),
    .mismatch_count  (mismatch_count)
  );

  always #6 clk = ~clk;

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_frame(input logic [63:0] t, input logic udp, input logic offl,
                            input logic [15:0] sum, input logic [15:0] osh,
                            input logic [31:0] osl, input logic [31:0] ons,
                            input logic [8:0] corr);
    @(negedge clk);
    start           <= 1'b1;
    in_time_ns      <= t;
    in_is_udp       <= udp;
    in_csum_offload <= offl;
    in_old_udp_sum  <= sum;
    in_old_sec_high <= osh;
    in_old_sec_low  <= osl;
    in_old_nanosec  <= ons;
    in_corr_offset  <= corr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_time();
    logic [63:0] secs;
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom);
      2: begin
        // just around a whole second
        secs = {30'd0, 2'($urandom_range(0, 3)), $urandom};
        return secs * NS_SEC64 + 64'($urandom_range(0, 4)) - 64'd2;
      end
      3: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 1999999999));
      4: return 64'($urandom_range(0, 16));
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic send_random_frame();
    logic [63:0] t;
    logic [63:0] secs;
    logic [63:0] ns;
    logic [15:0] sum;
    logic [15:0] osh;
    logic [31:0] osl;
    logic [31:0] ons;
    t    = pick_time();
    secs = t / NS_SEC64;
    ns   = t % NS_SEC64;
    case ($urandom_range(0, 15))
      0, 1:    sum = 16'd0;
      2:       sum = 16'hffff;
      default: sum = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      // unchanged words leave the checksum alone
      0, 1: begin
        osh = secs[47:32];
        osl = secs[31:0];
        ons = ns[31:0];
      end
      2: begin
        osh = 16'hffff;
        osl = 32'hffff_ffff;
        ons = 32'hffff_ffff;
      end
      3: begin
        osh = 16'd0;
        osl = 32'd0;
        ons = 32'd0;
      end
      default: begin
        osh = 16'($urandom);
        osl = $urandom;
        ons = $urandom;
      end
    endcase
    send_frame(t, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0, sum, osh, osl, ons,
               9'($urandom));
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_time_ns      = '0;
    in_is_udp       = 1'b0;
    in_csum_offload = 1'b0;
    in_old_udp_sum  = '0;
    in_old_sec_high = '0;
    in_old_sec_low  = '0;
    in_old_nanosec  = '0;
    in_corr_offset  = '0;
    idle_cycles     = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed corners, back to back
    send_frame(64'd0, 1'b0, 1'b0, 16'h1234, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 9'd0);
    send_frame(64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 16'hffff, 16'd0, 32'd0, 32'd0, 9'h1ff);
    send_frame(64'd999999999, 1'b1, 1'b1, 16'hbeef, 16'h1, 32'h2, 32'h3, 9'd42);
    send_frame(64'd1000000000, 1'b1, 1'b1, 16'd0, 16'h5, 32'h6, 32'h7, 9'd1);
    send_frame(64'd1000000000, 1'b1, 1'b0, 16'd0, 16'hffff, 32'h0, 32'h1, 9'd300);
    // update that folds to zero goes out as all ones
    send_frame(64'd0, 1'b1, 1'b0, 16'hffff, 16'd0, 32'd0, 32'd0, 9'd7);
    send_frame(64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 16'h0001, 16'hffff, 32'hffff_ffff,
               32'hffff_ffff, 9'h1ff);
    send_frame(64'h8000_0000_0000_0000, 1'b1, 1'b0, 16'hffff, 16'd0, 32'd0, 32'd0, 9'h1ff);
    send_frame(64'h0000_0001_0000_0000, 1'b1, 1'b0, 16'h8000, 16'h0, 32'h1, 32'h0, 9'h100);
    send_frame(64'd17179869183999999999, 1'b1, 1'b0, 16'h7fff, 16'h0004, 32'hffff_ffff,
               32'd999999999, 9'h0aa);
    send_frame(64'd17179869184000000000, 1'b1, 1'b0, 16'hfffe, 16'h0003, 32'h0, 32'h0, 9'h155);
    send_frame(64'd999999999, 1'b1, 1'b0, 16'h0001, 16'h0, 32'h0, 32'd999999999, 9'd0);
    send_frame(64'd1, 1'b0, 1'b1, 16'd0, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 9'd511);
    send_frame(64'd18446744073000000000, 1'b1, 1'b0, 16'h5a5a, 16'ha5a5, 32'h5a5a_a5a5,
               32'ha5a5_5a5a, 9'd255);
    send_frame(64'd18446744072999999999, 1'b1, 1'b1, 16'h0, 16'h0, 32'h0, 32'h0, 9'd256);
    send_frame(64'd1999999999, 1'b1, 1'b0, 16'hffff, 16'hffff, 32'hffff_ffff,
               32'hffff_ffff, 9'd0);
    pause_sender(5);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_frame();
        sent++;
      end
      // some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 12));
    end
    pause_sender(1);

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
